>>> hdl/lmss_pkg.sv
`default_nettype none

package lmss_pkg;

   localparam int unsigned MATRIX_SIZE = 8;
   localparam logic [2:0] MATRIX_LAST = 3'd7;

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   localparam logic [1:0] CSR_SCROLL_MODE  = 2'd0;
   localparam logic [1:0] CSR_CHAR_COUNT   = 2'd1;
   localparam logic [1:0] CSR_DWELL_FRAMES = 2'd2;
   localparam logic [1:0] CSR_REPEAT_COUNT = 2'd3;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] column_address;
      logic [7:0] column_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] row_pattern;
      logic [2:0] column_select;
      logic       scroll_done;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_ADDR = 3'b010,
      ST_DATA = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> hdl/lmss_ram.sv
`default_nettype none

module lmss_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hdl/led_matrix_scroll_scanner.sv
// 8x8 LED matrix column scanner with a scrolling text mode. Write words load
// the column-byte memory and restart words rewind the scroll; both are taken
// back to back. A tick word runs through accept, address and counter update,
// and registered memory read, and no new word is accepted until it is done;
// the display memory has a single read port and a registered read. A scroll
// mode tick is dropped with no result once stopped or while dwell frames is
// zero. A result waits in the output register while the next word is taken;
// a tick only stalls when the previous result has not been taken. No clearing
// pass is run: display memory entries are undefined until written.
`default_nettype none

module led_matrix_scroll_scanner #(
   parameter int unsigned MEMORY_DEPTH = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire lmss_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output lmss_pkg::rsp_word_type     rsp_word,
   input  wire logic                  csr_write_en,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data
);

   localparam int unsigned AW = $clog2(MEMORY_DEPTH);

   typedef logic [AW-1:0] mod_tab_type [256];

   function automatic mod_tab_type build_mod_table();
      mod_tab_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = AW'(i % MEMORY_DEPTH);
      end
      return t;
   endfunction

   localparam mod_tab_type MOD_TABLE = build_mod_table();

   // text position modulo total, on the character part only
   function automatic logic [7:0] reduce_pos(input logic [7:0] pos, input logic [5:0] chars);
      logic [5:0] rem;
      rem = '0;
      for (int i = 4; i >= 0; i--) begin
         rem = {rem[4:0], pos[3 + i]};
         if (rem >= chars) begin
            rem = rem - chars;
         end
      end
      return {rem[4:0], pos[2:0]};
   endfunction

   lmss_pkg::state_type state_ff, state_in;

   logic        scroll_mode_ff, scroll_mode_in;
   logic [5:0]  char_count_ff, char_count_in;
   logic [7:0]  dwell_frames_ff, dwell_frames_in;
   logic [7:0]  repeat_count_ff, repeat_count_in;

   logic [2:0]  slot_column_ff, slot_column_in;
   logic [3:0]  window_width_ff, window_width_in;
   logic [7:0]  dwell_counter_ff, dwell_counter_in;
   logic [7:0]  text_position_ff, text_position_in;
   logic [16:0] frame_counter_ff, frame_counter_in;
   logic        stopped_ff, stopped_in;

   logic [7:0]  pos_mod_ff, pos_mod_in;
   logic [15:0] frame_limit_ff, frame_limit_in;
   logic [2:0]  col_sel_ff, col_sel_in;
   logic        done_ff, done_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   lmss_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic          req_accept;
   logic [5:0]    chars_eff;
   logic [8:0]    total;
   logic          ram_wr_en;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [7:0]    ram_rd_data;

   logic [2:0]    c3;
   logic [9:0]    sum10;
   logic [7:0]    idx8;
   logic [3:0]    cn4;
   logic [8:0]    dwell9;
   logic [8:0]    pos_next;

   assign req_ready  = (state_ff == lmss_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign ram_wr_en  = req_accept && (req_word.opcode == lmss_pkg::OP_WRITE);

   assign chars_eff = (char_count_ff == 6'd0) ? 6'd1 :
                      (char_count_ff > 6'd32) ? 6'd32 : char_count_ff;
   assign total     = {chars_eff, 3'b000};

   lmss_ram #(
      .WIDTH(8),
      .DEPTH(MEMORY_DEPTH)
   ) u_display_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(MOD_TABLE[req_word.column_address]),
      .wr_data(req_word.column_byte),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      state_in         = state_ff;
      scroll_mode_in   = scroll_mode_ff;
      char_count_in    = char_count_ff;
      dwell_frames_in  = dwell_frames_ff;
      repeat_count_in  = repeat_count_ff;
      slot_column_in   = slot_column_ff;
      window_width_in  = window_width_ff;
      dwell_counter_in = dwell_counter_ff;
      text_position_in = text_position_ff;
      frame_counter_in = frame_counter_ff;
      stopped_in       = stopped_ff;
      pos_mod_in       = pos_mod_ff;
      frame_limit_in   = frame_limit_ff;
      col_sel_in       = col_sel_ff;
      done_in          = done_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_word_in      = rsp_word_ff;
      ram_rd_en        = 1'b0;
      ram_rd_addr      = '0;

      c3       = (4'(slot_column_ff) >= window_width_ff) ? 3'd0 : slot_column_ff;
      sum10    = 10'(pos_mod_ff) + 10'(total) - 10'(c3);
      if (sum10 >= 10'(total)) begin
         sum10 = sum10 - 10'(total);
      end
      idx8     = sum10[7:0];
      cn4      = 4'(c3) + 4'd1;
      dwell9   = 9'(dwell_counter_ff) + 9'd1;
      pos_next = 9'(pos_mod_ff) + 9'd1;

      if (csr_write_en) begin
         case (csr_index)
            lmss_pkg::CSR_SCROLL_MODE:  scroll_mode_in  = csr_data[0];
            lmss_pkg::CSR_CHAR_COUNT:   char_count_in   = csr_data[5:0];
            lmss_pkg::CSR_DWELL_FRAMES: dwell_frames_in = csr_data;
            lmss_pkg::CSR_REPEAT_COUNT: repeat_count_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         lmss_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_word.opcode)
                  lmss_pkg::OP_RESTART: begin
                     slot_column_in   = 3'd0;
                     window_width_in  = 4'd1;
                     dwell_counter_in = 8'd0;
                     text_position_in = 8'd0;
                     frame_counter_in = 17'd0;
                     stopped_in       = 1'b0;
                  end
                  lmss_pkg::OP_TICK: begin
                     if (!scroll_mode_ff) begin
                        state_in = lmss_pkg::ST_ADDR;
                     end else if (!stopped_ff && (dwell_frames_ff != 8'd0)) begin
                        pos_mod_in     = reduce_pos(text_position_ff, chars_eff);
                        frame_limit_in = 16'(total) * 16'(repeat_count_ff);
                        state_in       = lmss_pkg::ST_ADDR;
                     end
                  end
                  default: ;
               endcase
            end
         end
         lmss_pkg::ST_ADDR: begin
            ram_rd_en = 1'b1;
            state_in  = lmss_pkg::ST_DATA;
            if (!scroll_mode_ff) begin
               ram_rd_addr    = MOD_TABLE[{5'd0, slot_column_ff}];
               col_sel_in     = slot_column_ff;
               done_in        = 1'b0;
               slot_column_in = slot_column_ff + 3'd1;
            end else begin
               ram_rd_addr = MOD_TABLE[idx8];
               col_sel_in  = lmss_pkg::MATRIX_LAST - c3;
               done_in     = 1'b0;
               if (cn4 >= window_width_ff) begin
                  cn4 = 4'd0;
                  if (dwell9 >= 9'(dwell_frames_ff)) begin
                     dwell_counter_in = 8'd0;
                     if (frame_counter_ff >= 17'(frame_limit_ff)) begin
                        done_in    = 1'b1;
                        stopped_in = 1'b1;
                     end else begin
                        frame_counter_in = frame_counter_ff + 17'd1;
                        text_position_in = (pos_next == total) ? 8'd0 : pos_next[7:0];
                        if (window_width_ff < 4'(lmss_pkg::MATRIX_SIZE)) begin
                           window_width_in = window_width_ff + 4'd1;
                        end
                     end
                  end else begin
                     dwell_counter_in = dwell9[7:0];
                  end
               end
               slot_column_in = cn4[2:0];
            end
         end
         lmss_pkg::ST_DATA: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.row_pattern   = ram_rd_data;
               rsp_word_in.column_select = col_sel_ff;
               rsp_word_in.scroll_done   = done_ff;
               state_in                  = lmss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lmss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= lmss_pkg::ST_IDLE;
         scroll_mode_ff   <= 1'b0;
         char_count_ff    <= 6'd1;
         dwell_frames_ff  <= 8'd1;
         repeat_count_ff  <= 8'd1;
         slot_column_ff   <= 3'd0;
         window_width_ff  <= 4'd1;
         dwell_counter_ff <= 8'd0;
         text_position_ff <= 8'd0;
         frame_counter_ff <= 17'd0;
         stopped_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scroll_mode_ff   <= scroll_mode_in;
         char_count_ff    <= char_count_in;
         dwell_frames_ff  <= dwell_frames_in;
         repeat_count_ff  <= repeat_count_in;
         slot_column_ff   <= slot_column_in;
         window_width_ff  <= window_width_in;
         dwell_counter_ff <= dwell_counter_in;
         text_position_ff <= text_position_in;
         frame_counter_ff <= frame_counter_in;
         stopped_ff       <= stopped_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_mod_ff     <= pos_mod_in;
      frame_limit_ff <= frame_limit_in;
      col_sel_ff     <= col_sel_in;
      done_ff        <= done_in;
      rsp_word_ff    <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire
